// ===== rtl/two_byte_vehicle_command_decoder_top_defines.svh =====
// assertion macros for the two-byte vehicle command decoder
// used by tbvcd_mul and the top level; define ASSERT_OFF to drop all checks
`ifndef TWO_BYTE_VEHICLE_COMMAND_DECODER_TOP_DEFINES_SVH
`define TWO_BYTE_VEHICLE_COMMAND_DECODER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// checked only while out of reset
`define TBVCD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tbvcd assertion failed");
// checked at every edge, reset included
`define TBVCD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tbvcd assertion failed");
`else
`define TBVCD_ASSERT(lbl, clk, rstn, prop)
`define TBVCD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/tbvcd_pkg.sv =====
// shared types, codes and fixed-point constants for the vehicle command decoder
// no dependencies
package tbvcd_pkg;

    localparam int FRAC_BITS = 24;

    // servo coefficients, rounded to nearest
    localparam logic [63:0] SERVO_BASE =
        ((64'd1666 << FRAC_BITS) + 64'd50000) / 64'd100000;
    localparam logic [63:0] SERVO_SLOPE =
        ((64'd8334 << FRAC_BITS) + 64'd9000000) / 64'd18000000;
    localparam int COEF_W = $clog2(SERVO_BASE + 64'd255 * SERVO_SLOPE + 64'd1);

    // duty = floor(b*255/100) as b * (255*ceil(2^23/100)) >> 23, exact for 8-bit b
    localparam int          DUTY_SHIFT = 23;
    localparam logic [63:0] DUTY_RECIP = ((64'd1 << DUTY_SHIFT) + 64'd99) / 64'd100;
    localparam logic [63:0] DUTY_MCAND = 64'd255 * DUTY_RECIP;
    localparam int          DUTY_MC_W  = $clog2(DUTY_MCAND + 64'd1);

    localparam int MCAND_W  = (COEF_W > DUTY_MC_W) ? COEF_W : DUTY_MC_W;
    localparam int MPLIER_W = 16;
    localparam int ACC_W    = MCAND_W + MPLIER_W;

    // command codes
    localparam logic [2:0] CMD_FWD   = 3'd0;
    localparam logic [2:0] CMD_BWD   = 3'd1;
    localparam logic [2:0] CMD_SERVO = 3'd2;
    localparam logic [2:0] CMD_LON   = 3'd3;
    localparam logic [2:0] CMD_LOFF  = 3'd4;
    localparam logic [2:0] CMD_HORN  = 3'd5;

    // command letters
    localparam logic [7:0] CH_FWD   = 8'h66;
    localparam logic [7:0] CH_BWD   = 8'h62;
    localparam logic [7:0] CH_STEER = 8'h73;
    localparam logic [7:0] CH_LON   = 8'h6c;
    localparam logic [7:0] CH_LOFF  = 8'h64;
    localparam logic [7:0] CH_HORN  = 8'h68;

    // result status
    localparam logic [1:0] STAT_LATCHED = 2'd0;
    localparam logic [1:0] STAT_APPLIED = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    // drive direction
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BWD  = 2'd2;

    // configuration register index
    localparam logic [1:0] REG_PERIOD    = 2'd0;
    localparam logic [1:0] REG_ANGLE_MIN = 2'd1;
    localparam logic [1:0] REG_ANGLE_MAX = 2'd2;

    // reset values
    localparam logic [15:0] RST_PERIOD    = 16'd60000;
    localparam logic [7:0]  RST_ANGLE_MIN = 8'd60;
    localparam logic [7:0]  RST_ANGLE_MAX = 8'd110;
    localparam logic [7:0]  RST_DUTY      = 8'd127;
    localparam logic [15:0] RST_PULSE     = 16'd3360;

    typedef struct packed {
        logic                start;
        logic [ACC_W-1:0]    addend;
        logic [ACC_W-1:0]    mcand;
        logic [MPLIER_W-1:0] mplier;
    } t_mul_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ACC_W-1:0] product;
    } t_mul_rsp;

endpackage

// ===== rtl/tbvcd_mul.sv =====
// shared shift-add multiply-accumulate unit: product = addend + mcand * mplier
// one multiplier bit per cycle, stops early once the remaining multiplier bits are zero
// depends on tbvcd_pkg and the defines header
`include "two_byte_vehicle_command_decoder_top_defines.svh"

module tbvcd_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tbvcd_pkg::t_mul_req i_req,
    output tbvcd_pkg::t_mul_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [tbvcd_pkg::ACC_W-1:0]    r_acc;
    logic [tbvcd_pkg::ACC_W-1:0]    r_mcand;
    logic [tbvcd_pkg::MPLIER_W-1:0] r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_mplier == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc    <= i_req.addend;
            r_mcand  <= i_req.mcand;
            r_mplier <= i_req.mplier;
        end else if (r_busy && (r_mplier != '0)) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

    `TBVCD_ASSERT(a_no_start_busy, i_clk, i_rst_n, i_req.start |-> !r_busy)
    `TBVCD_ASSERT(a_done_idle, i_clk, i_rst_n, r_done |-> !r_busy)
    `TBVCD_ASSERT(a_finish, i_clk, i_rst_n,
        (r_busy && (r_mplier == '0) && !i_req.start) |=> (r_done && !r_busy))

endmodule

// ===== rtl/two_byte_vehicle_command_decoder_top.sv =====
// command bytes and non-arithmetic arguments go from accept to S_DONE, then load the result beat;
// drive and steer arguments first pass through the multiplier (one shared shift-add
// multiplier walks the multiplier bits, twice for steer: coefficient then period)
// a new byte is taken only after the previous result is loaded, which waits while the output register is full
// reset: synchronous active-low i_rst_n restores control, configuration and vehicle state defaults
// depends on tbvcd_pkg, tbvcd_mul and the defines header
`include "two_byte_vehicle_command_decoder_top_defines.svh"

module two_byte_vehicle_command_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // received bytes
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_drive_duty,
    output logic [1:0]  o_drive_direction,
    output logic [15:0] o_steer_pulse,
    output logic        o_lights_on,
    output logic        o_horn_on
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DUTY  = 3'd1;
    localparam logic [2:0] S_COEF  = 3'd2;
    localparam logic [2:0] S_PULSE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam int ACC_W = tbvcd_pkg::ACC_W;
    localparam logic [ACC_W-1:0] DUTY_MAX  = ACC_W'(255);
    localparam logic [ACC_W-1:0] PULSE_MAX = ACC_W'(16'hFFFF);

    logic [2:0]  r_state, n_state;
    logic [15:0] r_period;
    logic [7:0]  r_angle_min, r_angle_max;
    logic        r_await;
    logic [2:0]  r_pcmd;
    logic [7:0]  r_duty;
    logic [1:0]  r_dir;
    logic [15:0] r_pulse;
    logic        r_lights, r_horn;
    logic [1:0]  r_stat;
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [7:0]  r_out_duty;
    logic [1:0]  r_out_dir;
    logic [15:0] r_out_pulse;
    logic        r_out_lights, r_out_horn;

    tbvcd_pkg::t_mul_req w_req;
    tbvcd_pkg::t_mul_rsp w_rsp;

    logic             w_in_acc;
    logic             w_out_load;
    logic             w_cmd_ok;
    logic [2:0]       w_cmd;
    logic [7:0]       w_angle;
    logic [ACC_W-1:0] w_duty_sh;
    logic [ACC_W-1:0] w_pulse_sh;
    logic [7:0]       w_duty_new;
    logic [15:0]      w_pulse_new;

    tbvcd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // command letter decode
    always_comb begin
        w_cmd_ok = 1'b1;
        w_cmd    = tbvcd_pkg::CMD_FWD;
        case (i_rx_byte)
            tbvcd_pkg::CH_FWD:   w_cmd = tbvcd_pkg::CMD_FWD;
            tbvcd_pkg::CH_BWD:   w_cmd = tbvcd_pkg::CMD_BWD;
            tbvcd_pkg::CH_STEER: w_cmd = tbvcd_pkg::CMD_SERVO;
            tbvcd_pkg::CH_LON:   w_cmd = tbvcd_pkg::CMD_LON;
            tbvcd_pkg::CH_LOFF:  w_cmd = tbvcd_pkg::CMD_LOFF;
            tbvcd_pkg::CH_HORN:  w_cmd = tbvcd_pkg::CMD_HORN;
            default:             w_cmd_ok = 1'b0;
        endcase
    end

    // upper limit tested first: with crossed limits bytes above angle_max give angle_max, others angle_min
    always_comb begin
        if (i_rx_byte > r_angle_max) begin
            w_angle = r_angle_max;
        end else if (i_rx_byte < r_angle_min) begin
            w_angle = r_angle_min;
        end else begin
            w_angle = i_rx_byte;
        end
    end

    assign w_duty_sh   = w_rsp.product >> tbvcd_pkg::DUTY_SHIFT;
    assign w_pulse_sh  = w_rsp.product >> tbvcd_pkg::FRAC_BITS;
    assign w_duty_new  = (w_duty_sh > DUTY_MAX) ? 8'hFF : w_duty_sh[7:0];
    assign w_pulse_new = (w_pulse_sh > PULSE_MAX) ? 16'hFFFF : w_pulse_sh[15:0];

    // sequencer and multiplier requests
    always_comb begin
        n_state      = r_state;
        w_req.start  = 1'b0;
        w_req.addend = '0;
        w_req.mcand  = '0;
        w_req.mplier = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_DONE;
                    if (r_await) begin
                        if ((r_pcmd == tbvcd_pkg::CMD_FWD) ||
                            (r_pcmd == tbvcd_pkg::CMD_BWD)) begin
                            w_req.start  = 1'b1;
                            w_req.mcand  = ACC_W'(tbvcd_pkg::DUTY_MCAND);
                            w_req.mplier = {8'd0, i_rx_byte};
                            n_state      = S_DUTY;
                        end else if (r_pcmd == tbvcd_pkg::CMD_SERVO) begin
                            w_req.start  = 1'b1;
                            w_req.addend = ACC_W'(tbvcd_pkg::SERVO_BASE);
                            w_req.mcand  = ACC_W'(tbvcd_pkg::SERVO_SLOPE);
                            w_req.mplier = {8'd0, w_angle};
                            n_state      = S_COEF;
                        end
                    end
                end
            end
            S_DUTY: begin
                if (w_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_COEF: begin
                // second pass: coefficient times period
                if (w_rsp.done) begin
                    w_req.start  = 1'b1;
                    w_req.mcand  = w_rsp.product;
                    w_req.mplier = r_period;
                    n_state      = S_PULSE;
                end
            end
            S_PULSE: begin
                if (w_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= tbvcd_pkg::RST_PERIOD;
            r_angle_min <= tbvcd_pkg::RST_ANGLE_MIN;
            r_angle_max <= tbvcd_pkg::RST_ANGLE_MAX;
            r_await     <= 1'b0;
            r_pcmd      <= tbvcd_pkg::CMD_FWD;
            r_duty      <= tbvcd_pkg::RST_DUTY;
            r_dir       <= tbvcd_pkg::DIR_NONE;
            r_pulse     <= tbvcd_pkg::RST_PULSE;
            r_lights    <= 1'b0;
            r_horn      <= 1'b0;
            r_stat      <= tbvcd_pkg::STAT_LATCHED;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tbvcd_pkg::REG_PERIOD:    r_period    <= i_cfg_data;
                    tbvcd_pkg::REG_ANGLE_MIN: r_angle_min <= i_cfg_data[7:0];
                    tbvcd_pkg::REG_ANGLE_MAX: r_angle_max <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (w_in_acc) begin
                if (!r_await) begin
                    if (w_cmd_ok) begin
                        r_pcmd  <= w_cmd;
                        r_await <= 1'b1;
                        r_stat  <= tbvcd_pkg::STAT_LATCHED;
                    end else begin
                        r_stat  <= tbvcd_pkg::STAT_INVALID;
                    end
                end else begin
                    r_await <= 1'b0;
                    r_stat  <= tbvcd_pkg::STAT_APPLIED;
                    case (r_pcmd)
                        tbvcd_pkg::CMD_FWD:  r_dir    <= tbvcd_pkg::DIR_FWD;
                        tbvcd_pkg::CMD_BWD:  r_dir    <= tbvcd_pkg::DIR_BWD;
                        tbvcd_pkg::CMD_LON:  r_lights <= 1'b1;
                        tbvcd_pkg::CMD_LOFF: r_lights <= 1'b0;
                        tbvcd_pkg::CMD_HORN: begin
                            if (i_rx_byte == 8'd0) begin
                                r_horn <= 1'b0;
                            end else if (i_rx_byte == 8'd1) begin
                                r_horn <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            if ((r_state == S_DUTY) && w_rsp.done) begin
                r_duty <= w_duty_new;
            end
            if ((r_state == S_PULSE) && w_rsp.done) begin
                r_pulse <= w_pulse_new;
            end

            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_stat;
            r_out_duty   <= r_duty;
            r_out_dir    <= r_dir;
            r_out_pulse  <= r_pulse;
            r_out_lights <= r_lights;
            r_out_horn   <= r_horn;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_drive_duty      = r_out_duty;
    assign o_drive_direction = r_out_dir;
    assign o_steer_pulse     = r_out_pulse;
    assign o_lights_on       = r_out_lights;
    assign o_horn_on         = r_out_horn;

    `TBVCD_ASSERT(a_mul_active, i_clk, i_rst_n,
        ((r_state == S_DUTY) || (r_state == S_COEF) || (r_state == S_PULSE))
            |-> (w_rsp.busy || w_rsp.done))
    `TBVCD_ASSERT(a_latch_direct, i_clk, i_rst_n, $rose(r_await) |-> (r_state == S_DONE))
    `TBVCD_ASSERT(a_idle_mul, i_clk, i_rst_n,
        ((r_state == S_IDLE) || (r_state == S_DONE)) |-> !w_rsp.busy)

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the two-byte vehicle command decoder
// drives byte and register channels, predicts every result beat, depends on tbvcd_pkg and the decoder top
`timescale 1ns / 1ps

module tb_top;

    localparam int          PULSE_FRAC  = tbvcd_pkg::FRAC_BITS;
    localparam logic [63:0] PULSE_BASE  = ((64'd1666 << PULSE_FRAC) + 64'd50000) / 64'd100000;
    localparam logic [63:0] PULSE_SLOPE = ((64'd8334 << PULSE_FRAC) + 64'd9000000)
                                          / 64'd18000000;
    localparam int          STALL_LIMIT = 2000;
    localparam int          LONG_HOLD   = 400;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  duty;
        logic [1:0]  direction;
        logic [15:0] pulse;
        logic        lights;
        logic        horn;
    } t_vehicle_report;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [1:0]  cfg_index   = '0;
    logic [15:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic [7:0]  rx_byte     = '0;
    logic        out_ready   = 1'b0;
    wire         cfg_ready;
    wire         in_ready;
    wire         out_valid;
    wire  [1:0]  status;
    wire  [7:0]  drive_duty;
    wire  [1:0]  drive_direction;
    wire  [15:0] steer_pulse;
    wire         lights_on;
    wire         horn_on;

    // predicted decoder state and registers
    logic [15:0] servo_period;
    logic [7:0]  angle_lo;
    logic [7:0]  angle_hi;
    logic        want_arg;
    logic [2:0]  held_cmd;
    logic [7:0]  duty_now;
    logic [1:0]  dir_now;
    logic [15:0] pulse_now;
    logic        lights_now;
    logic        horn_now;

    logic [7:0]      tx_bytes [$];
    t_vehicle_report expected_reports [$];

    int  mismatches  = 0;
    int  idle_cycles = 0;
    int  gap_left    = 0;
    int  hold_left   = 0;
    bit  byte_taken  = 1'b0;
    bit  in_idle_en  = 1'b1;
    bit  out_idle_en = 1'b1;
    bit  hold_req    = 1'b0;

    two_byte_vehicle_command_decoder_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_rx_byte         (rx_byte),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_status          (status),
        .o_drive_duty      (drive_duty),
        .o_drive_direction (drive_direction),
        .o_steer_pulse     (steer_pulse),
        .o_lights_on       (lights_on),
        .o_horn_on         (horn_on)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void reset_vehicle();
        servo_period = tbvcd_pkg::RST_PERIOD;
        angle_lo     = tbvcd_pkg::RST_ANGLE_MIN;
        angle_hi     = tbvcd_pkg::RST_ANGLE_MAX;
        want_arg     = 1'b0;
        held_cmd     = tbvcd_pkg::CMD_FWD;
        duty_now     = tbvcd_pkg::RST_DUTY;
        dir_now      = tbvcd_pkg::DIR_NONE;
        pulse_now    = tbvcd_pkg::RST_PULSE;
        lights_now   = 1'b0;
        horn_now     = 1'b0;
    endfunction

    // applies one received byte to the vehicle state and returns the report beat
    function automatic t_vehicle_report decode_byte(input logic [7:0] b);
        t_vehicle_report r;
        logic            hit;
        logic [2:0]      code;
        logic [15:0]     duty_full;
        logic [7:0]      ang;
        logic [63:0]     counts;
        hit  = 1'b1;
        code = tbvcd_pkg::CMD_FWD;
        if (!want_arg) begin
            case (b)
                tbvcd_pkg::CH_FWD:   code = tbvcd_pkg::CMD_FWD;
                tbvcd_pkg::CH_BWD:   code = tbvcd_pkg::CMD_BWD;
                tbvcd_pkg::CH_STEER: code = tbvcd_pkg::CMD_SERVO;
                tbvcd_pkg::CH_LON:   code = tbvcd_pkg::CMD_LON;
                tbvcd_pkg::CH_LOFF:  code = tbvcd_pkg::CMD_LOFF;
                tbvcd_pkg::CH_HORN:  code = tbvcd_pkg::CMD_HORN;
                default:             hit = 1'b0;
            endcase
            if (hit) begin
                held_cmd = code;
                want_arg = 1'b1;
                r.status = tbvcd_pkg::STAT_LATCHED;
            end else begin
                r.status = tbvcd_pkg::STAT_INVALID;
            end
        end else begin
            case (held_cmd)
                tbvcd_pkg::CMD_FWD, tbvcd_pkg::CMD_BWD: begin
                    duty_full = (16'(b) * 16'd255) / 16'd100;
                    duty_now  = (duty_full > 16'd255) ? 8'd255 : duty_full[7:0];
                    dir_now   = (held_cmd == tbvcd_pkg::CMD_FWD) ? tbvcd_pkg::DIR_FWD
                                                                 : tbvcd_pkg::DIR_BWD;
                end
                tbvcd_pkg::CMD_SERVO: begin
                    // upper limit tested first; with crossed limits bytes at or below it get the lower limit
                    ang = b;
                    if (ang > angle_hi)
                        ang = angle_hi;
                    else if (ang < angle_lo)
                        ang = angle_lo;
                    counts = (64'(servo_period) * (PULSE_BASE + 64'(ang) * PULSE_SLOPE))
                             >> PULSE_FRAC;
                    pulse_now = (counts > 64'hFFFF) ? 16'hFFFF : counts[15:0];
                end
                tbvcd_pkg::CMD_LON:  lights_now = 1'b1;
                tbvcd_pkg::CMD_LOFF: lights_now = 1'b0;
                tbvcd_pkg::CMD_HORN: begin
                    if (b == 8'd0)
                        horn_now = 1'b0;
                    else if (b == 8'd1)
                        horn_now = 1'b1;
                end
                default: ;
            endcase
            want_arg = 1'b0;
            r.status = tbvcd_pkg::STAT_APPLIED;
        end
        r.duty      = duty_now;
        r.direction = dir_now;
        r.pulse     = pulse_now;
        r.lights    = lights_now;
        r.horn      = horn_now;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60)
            return int'($urandom_range(1, 2));
        else if (r < 90)
            return int'($urandom_range(3, 8));
        else
            return int'($urandom_range(20, 90));
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // sampling side: prediction on byte beats, checking on result beats
    always @(posedge i_clk) begin
        t_vehicle_report want;
        bit              moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                case (cfg_index)
                    tbvcd_pkg::REG_PERIOD:    servo_period = cfg_data;
                    tbvcd_pkg::REG_ANGLE_MIN: angle_lo = cfg_data[7:0];
                    tbvcd_pkg::REG_ANGLE_MAX: angle_hi = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                moved = 1'b1;
                byte_taken = 1'b1;
                expected_reports.push_back(decode_byte(rx_byte));
            end
            if (out_valid && out_ready) begin
                moved = 1'b1;
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    $display({"%0t: result beat with nothing expected, ",
                              "expected none, actual status %0d"}, $time, status);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("drive_duty", 32'(want.duty), 32'(drive_duty));
                    check_field("drive_direction", 32'(want.direction),
                                32'(drive_direction));
                    check_field("steer_pulse", 32'(want.pulse), 32'(steer_pulse));
                    check_field("lights_on", 32'(want.lights), 32'(lights_on));
                    check_field("horn_on", 32'(want.horn), 32'(horn_on));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // byte driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !byte_taken) begin
            // hold the beat until it is taken
        end else if (gap_left > 0) begin
            in_valid <= 1'b0;
            gap_left--;
        end else if (tx_bytes.size() != 0) begin
            in_valid <= 1'b1;
            rx_byte  <= tx_bytes.pop_front();
            gap_left = (in_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        end else begin
            in_valid <= 1'b0;
        end
        byte_taken = 1'b0;
    end

    // result receiver
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
            out_ready <= 1'b0;
            hold_left = pick_gap() - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("** two_byte_vehicle_command_decoder_top: FAILED **");
        $finish;
    end

    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (tx_bytes.size() != 0 || in_valid || expected_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_servo(input logic [15:0] period, input logic [15:0] lo,
                             input logic [15:0] hi);
        write_reg(tbvcd_pkg::REG_PERIOD, period);
        write_reg(tbvcd_pkg::REG_ANGLE_MIN, lo);
        write_reg(tbvcd_pkg::REG_ANGLE_MAX, hi);
    endtask

    // mostly command/argument pairs, some stray bytes that break the pairing
    task automatic queue_traffic(input int count);
        int         n;
        logic [7:0] letter;
        logic [7:0] arg;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 99) < 85) begin
                case ($urandom_range(0, 5))
                    0: letter = tbvcd_pkg::CH_FWD;
                    1: letter = tbvcd_pkg::CH_BWD;
                    2: letter = tbvcd_pkg::CH_STEER;
                    3: letter = tbvcd_pkg::CH_LON;
                    4: letter = tbvcd_pkg::CH_LOFF;
                    default: letter = tbvcd_pkg::CH_HORN;
                endcase
                arg = 8'($urandom_range(0, 255));
                if ((letter == tbvcd_pkg::CH_FWD || letter == tbvcd_pkg::CH_BWD) &&
                    $urandom_range(0, 1))
                    arg = 8'($urandom_range(0, 100));
                else if (letter == tbvcd_pkg::CH_STEER)
                    case ($urandom_range(0, 5))
                        0: arg = angle_lo;
                        1: arg = angle_lo - 8'd1;
                        2: arg = angle_hi;
                        3: arg = angle_hi + 8'd1;
                        default: ;
                    endcase
                else if (letter == tbvcd_pkg::CH_HORN && $urandom_range(0, 3) != 0)
                    arg = 8'($urandom_range(0, 2));
                tx_bytes.push_back(letter);
                tx_bytes.push_back(arg);
                n += 2;
            end else begin
                tx_bytes.push_back(8'($urandom_range(0, 255)));
                n++;
            end
        end
    endtask

    initial begin
        int k;
        reset_vehicle();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset limits, extremes of every command
        tx_bytes = '{8'h00, 8'hFF,
                     tbvcd_pkg::CH_FWD, 8'd0, tbvcd_pkg::CH_FWD, 8'd100,
                     tbvcd_pkg::CH_BWD, 8'd255, tbvcd_pkg::CH_BWD, 8'd39,
                     tbvcd_pkg::CH_STEER, 8'd0, tbvcd_pkg::CH_STEER, 8'd255,
                     tbvcd_pkg::CH_STEER, 8'd85,
                     tbvcd_pkg::CH_LON, 8'hAA, tbvcd_pkg::CH_LOFF, tbvcd_pkg::CH_LON,
                     tbvcd_pkg::CH_HORN, 8'd1, tbvcd_pkg::CH_HORN, 8'd2,
                     tbvcd_pkg::CH_HORN, 8'd0};
        wait_drained();

        // widest limits, largest period, no idling
        set_servo(16'hFFFF, 16'd0, 16'd180);
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        queue_traffic(250);
        wait_drained();

        // crossed limits, smallest nonzero period
        set_servo(16'd1, 16'd180, 16'd0);
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        queue_traffic(200);
        wait_drained();

        // zero period, limits above 180, upper data bits ignored, unused index
        write_reg(2'd3, 16'h5A5A);
        set_servo(16'd0, 16'hFFC8, 16'h00FF);
        queue_traffic(200);
        wait_drained();

        // receiver holds off while bytes keep coming
        set_servo(16'd40000, 16'd90, 16'd90);
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        hold_req    = 1'b1;
        queue_traffic(200);
        wait_drained();

        for (k = 0; k < 4; k++) begin
            set_servo(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 180)),
                      16'($urandom_range(0, 180)));
            in_idle_en  = 1'($urandom_range(0, 1));
            out_idle_en = 1'($urandom_range(0, 1));
            queue_traffic(160);
            wait_drained();
        end

        repeat (64) @(posedge i_clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("** two_byte_vehicle_command_decoder_top: PASSED **");
        else
            $display("** two_byte_vehicle_command_decoder_top: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tbvcd_pkg.sv
rtl/tbvcd_mul.sv
rtl/two_byte_vehicle_command_decoder_top.sv
verif/tb_top.sv
